>>> rtl/supply_profile_selector_top_macros.svh
// assertion macros of the supply profile selector
`ifndef SUPPLY_PROFILE_SELECTOR_TOP_MACROS_SVH
`define SUPPLY_PROFILE_SELECTOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sps_pkg.sv
// types, constants and tables of the supply profile selector
package sps_pkg;

    // slot table geometry
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_CW    = $clog2(SLOT_COUNT + 1);
    localparam logic [SLOT_CW-1:0] SCAN_LAST = SLOT_CW'(SLOT_COUNT - 1);

    // voltages in 0.1 V units
    localparam int VOLT_W        = 9;
    localparam int BUS_W         = 8;
    localparam int HEADROOM_W    = 7;
    localparam int PROFILE_COUNT = 6;
    localparam logic [VOLT_W-1:0] VOLT_MAX      = 9'd511;
    localparam logic [VOLT_W-1:0] NO_CTRL_LIMIT = 9'd55;
    localparam logic [VOLT_W:0]   MARGIN        = 10'd5;

    // profile voltages, ascending: 5, 9, 12, 15, 18, 20 V
    localparam logic [PROFILE_COUNT-1:0][BUS_W-1:0] PROFILE_VOLTS =
        {8'd200, 8'd180, 8'd150, 8'd120, 8'd90, 8'd50};

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_MINIMUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCK_HEADROOM = 1'b1;

    // reset values of the configuration registers
    localparam logic [VOLT_W-1:0]     BOARD_MINIMUM_RST = 9'd90;
    localparam logic [HEADROOM_W-1:0] BUCK_HEADROOM_RST = 7'd15;

    // command codes
    localparam logic FUNC_ENSURE = 1'b0;
    localparam logic FUNC_VERIFY = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_SATISFIED    = 3'd0,
        ST_NEGOTIATE    = 3'd1,
        ST_INVALID_SLOT = 3'd2,
        ST_UNAVAILABLE  = 3'd3,
        ST_NOT_ATTACHED = 3'd4,
        ST_INSUFFICIENT = 3'd5
    } status_t;

    // input word
    typedef struct packed {
        logic                     func;
        logic [3:0]               consumer_id;
        logic [VOLT_W-1:0]        output_volts;
        logic                     is_buck_boost;
        logic                     controller_present;
        logic                     cable_attached;
        logic [PROFILE_COUNT-1:0] offered_mask;
        logic [BUS_W-1:0]         bus_volts;
    } sps_in_t;

    // result word
    typedef struct packed {
        status_t           status;
        logic [2:0]        target_profile;
        logic [VOLT_W-1:0] required_volts;
        logic              success;
    } sps_out_t;

    // one slot table entry
    typedef struct packed {
        logic              is_buck_boost;
        logic [VOLT_W-1:0] volts;
    } sps_entry_t;

    // slot memory access from the controller
    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        sps_entry_t         wdata;
        logic               re;
        logic [SLOT_AW-1:0] raddr;
    } sps_mem_req_t;

endpackage

>>> rtl/sps_decide.sv
// profile choice and status decision for an ensure word
module sps_decide (
    input  logic [sps_pkg::VOLT_W-1:0]        req,
    input  sps_pkg::sps_in_t                  held,
    output sps_pkg::sps_out_t                 res
);

    logic [sps_pkg::PROFILE_COUNT-1:0] covers;
    logic [2:0]                        first_idx;
    logic                              first_found;
    logic [2:0]                        high_idx;
    logic [2:0]                        target;
    logic [sps_pkg::BUS_W-1:0]         tv;
    logic                              near;

    // which profiles reach the requirement minus the margin
    always_comb
    begin
        for (int i = 0; i < sps_pkg::PROFILE_COUNT; i++)
        begin
            covers[i] = ({2'b00, sps_pkg::PROFILE_VOLTS[i]} + sps_pkg::MARGIN)
                        >= {1'b0, req};
        end
    end

    // lowest covering offered profile, else highest offered
    always_comb
    begin
        first_idx   = 3'd0;
        first_found = 1'b0;
        high_idx    = 3'd0;
        for (int i = sps_pkg::PROFILE_COUNT - 1; i >= 0; i--)
        begin
            if (covers[i] && held.offered_mask[i])
            begin
                first_idx   = 3'(i);
                first_found = 1'b1;
            end
        end
        for (int i = 0; i < sps_pkg::PROFILE_COUNT; i++)
        begin
            if (held.offered_mask[i])
            begin
                high_idx = 3'(i);
            end
        end
        target = first_found ? first_idx : high_idx;
    end

    // present bus voltage within the margin of the chosen profile
    assign tv   = sps_pkg::PROFILE_VOLTS[target];
    assign near = (({2'b00, held.bus_volts} + sps_pkg::MARGIN) > {2'b00, tv}) &&
                  (({2'b00, tv} + sps_pkg::MARGIN) > {2'b00, held.bus_volts});

    // status word
    always_comb
    begin
        res.required_volts = req;
        res.target_profile = 3'd0;
        res.success        = 1'b0;
        res.status         = sps_pkg::ST_SATISFIED;
        if (!held.controller_present)
        begin
            res.success = (req <= sps_pkg::NO_CTRL_LIMIT);
            res.status  = res.success ? sps_pkg::ST_SATISFIED : sps_pkg::ST_UNAVAILABLE;
        end
        else if (!held.cable_attached)
        begin
            res.status = sps_pkg::ST_NOT_ATTACHED;
        end
        else
        begin
            res.target_profile = target;
            if (near)
            begin
                res.status  = sps_pkg::ST_SATISFIED;
                res.success = 1'b1;
            end
            else
            begin
                res.status  = sps_pkg::ST_NEGOTIATE;
                res.success = covers[target];
            end
        end
    end

endmodule

>>> rtl/sps_slot_mem.sv
// slot table memory with per-entry valid bits cleared at reset
module sps_slot_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sps_pkg::sps_mem_req_t req,
    output sps_pkg::sps_entry_t   rd_entry
);

    sps_pkg::sps_entry_t              mem [sps_pkg::SLOT_COUNT];
    logic [sps_pkg::SLOT_COUNT-1:0]   valid_reg;
    sps_pkg::sps_entry_t              rd_data_reg;
    logic                             rd_vld_reg;

    // storage array, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    // valid bits and read valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_vld_reg <= valid_reg[req.raddr];
            end
        end
    end

    // never-written entries read as idle
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> rtl/sps_ctrl.sv
// sequencer: slot write, table scan, requirement accumulate and result word
`include "supply_profile_selector_top_macros.svh"

module sps_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sps_pkg::sps_in_t                    cmd,
    input  logic [sps_pkg::VOLT_W-1:0]          board_minimum,
    input  logic [sps_pkg::HEADROOM_W-1:0]      buck_headroom,
    output sps_pkg::sps_mem_req_t               mem_req,
    input  sps_pkg::sps_entry_t                 rd_entry,
    output logic                                done,
    output sps_pkg::sps_out_t                   result
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [sps_pkg::SLOT_CW-1:0]    cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;
    logic [sps_pkg::VOLT_W-1:0]     req_reg, req_next;
    logic [sps_pkg::VOLT_W-1:0]     last_req_reg, last_req_next;
    sps_pkg::sps_in_t               hold_reg, hold_next;
    sps_pkg::sps_out_t              result_reg, result_next;
    logic                           done_reg, done_next;

    sps_pkg::sps_out_t              dec_res;
    logic [sps_pkg::VOLT_W:0]       need_sum;
    logic [sps_pkg::VOLT_W-1:0]     need;
    logic                           slot_bad;
    logic                           verify_ok;

    // profile choice on the finished requirement
    sps_decide u_decide (
        .req  (req_reg),
        .held (hold_reg),
        .res  (dec_res)
    );

    // requirement of the entry coming out of memory
    assign need_sum = {1'b0, rd_entry.volts} + {3'b000, buck_headroom};
    always_comb
    begin
        if (rd_entry.is_buck_boost)
        begin
            need = rd_entry.volts;
        end
        else if (need_sum[sps_pkg::VOLT_W])
        begin
            need = sps_pkg::VOLT_MAX;
        end
        else
        begin
            need = need_sum[sps_pkg::VOLT_W-1:0];
        end
    end

    assign slot_bad  = {1'b0, cmd.consumer_id} >= 5'(sps_pkg::SLOT_COUNT);
    assign verify_ok = ({2'b00, cmd.bus_volts} + sps_pkg::MARGIN) >= {1'b0, last_req_reg};

    // next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = (state_reg == S_SCAN);
        req_next      = req_reg;
        last_req_next = last_req_reg;
        hold_next     = hold_reg;
        result_next   = result_reg;
        done_next     = 1'b0;

        mem_req       = '0;
        mem_req.waddr = cmd.consumer_id[sps_pkg::SLOT_AW-1:0];
        mem_req.wdata = '{is_buck_boost: cmd.is_buck_boost, volts: cmd.output_volts};
        mem_req.raddr = cnt_reg[sps_pkg::SLOT_AW-1:0];

        // running maximum over active slots
        if (pend_reg && (rd_entry.volts != '0) && (need > req_reg))
        begin
            req_next = need;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == sps_pkg::FUNC_VERIFY)
                    begin
                        result_next.status         = verify_ok ? sps_pkg::ST_SATISFIED
                                                               : sps_pkg::ST_INSUFFICIENT;
                        result_next.target_profile = 3'd0;
                        result_next.required_volts = last_req_reg;
                        result_next.success        = verify_ok;
                        done_next                  = 1'b1;
                    end
                    else if (slot_bad)
                    begin
                        result_next.status         = sps_pkg::ST_INVALID_SLOT;
                        result_next.target_profile = 3'd0;
                        result_next.required_volts = '0;
                        result_next.success        = 1'b0;
                        done_next                  = 1'b1;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                        hold_next  = cmd;
                        req_next   = board_minimum;
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                mem_req.re = 1'b1;
                cnt_next   = cnt_reg + sps_pkg::SLOT_CW'(1);
                if (cnt_reg == sps_pkg::SCAN_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                result_next   = dec_res;
                last_req_next = req_reg;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            last_req_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            last_req_reg <= last_req_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // sequencing checks
    `SPS_ASSERT_NEXT(a_ensure_starts_scan, clk, rst_n,
        (start && !busy && (cmd.func == sps_pkg::FUNC_ENSURE) && !slot_bad),
        ((state_reg == S_SCAN) && (cnt_reg == '0)), "ensure word did not start a scan")
    `SPS_ASSERT_NEXT(a_scan_runs, clk, rst_n,
        ((state_reg == S_SCAN) && (cnt_reg != sps_pkg::SCAN_LAST)),
        (state_reg == S_SCAN), "scan ended early")
    `SPS_ASSERT_NEXT(a_drain_decides, clk, rst_n,
        (state_reg == S_DRAIN), ((state_reg == S_DECIDE) && !pend_reg),
        "drain not followed by decision")
    `SPS_ASSERT_NOW(a_done_source, clk, rst_n,
        done, ($past(state_reg == S_DECIDE) || $past(start && !busy)),
        "result word without a cause")

endmodule

>>> rtl/supply_profile_selector_top.sv
// top level of the supply profile selector: configuration registers and wiring
//
// Usage:
//   A command word is taken on cmd at a rising edge with start high and busy
//   low. Each command gives exactly one result word on result, shown for one
//   cycle with done high; the receiver cannot stall, so it must take it then.
//   Verify commands and ensure commands naming a slot outside the table
//   answer in the next cycle and leave busy low.
//   A valid ensure command writes its slot into the slot memory at the accept
//   edge, then reads the table back one slot per cycle through the memory's
//   single registered read port to build the requirement, then picks the
//   profile. busy stays high through the scan, drain and decide states, and
//   done rises as busy falls, when the decide state hands back to idle; the
//   next command may be taken at the edge that ends the done cycle.
//   Configuration: cfg_we, cfg_idx and cfg_data write board_minimum (index 0)
//   or buck_headroom (index 1) at any edge; only write while idle.
//   Reset (rst_n low, asynchronous) returns the board minimum to 9.0 V and the
//   headroom to 1.5 V, marks every slot idle and clears the stored
//   requirement; no clearing pass is needed.
module supply_profile_selector_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sps_pkg::sps_in_t                  cmd,
    output logic                              done,
    output sps_pkg::sps_out_t                 result,
    input  logic                              cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [sps_pkg::VOLT_W-1:0]     board_min_reg;
    logic [sps_pkg::HEADROOM_W-1:0] headroom_reg;
    sps_pkg::sps_mem_req_t          mem_req;
    sps_pkg::sps_entry_t            rd_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_min_reg <= sps_pkg::BOARD_MINIMUM_RST;
            headroom_reg  <= sps_pkg::BUCK_HEADROOM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                sps_pkg::CFG_BOARD_MINIMUM:
                begin
                    board_min_reg <= cfg_data[sps_pkg::VOLT_W-1:0];
                end
                sps_pkg::CFG_BUCK_HEADROOM:
                begin
                    headroom_reg <= cfg_data[sps_pkg::HEADROOM_W-1:0];
                end
                default:
                begin
                    board_min_reg <= board_min_reg;
                end
            endcase
        end
    end

    // slot table
    sps_slot_mem u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    // sequencer
    sps_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .board_minimum (board_min_reg),
        .buck_headroom (headroom_reg),
        .mem_req       (mem_req),
        .rd_entry      (rd_entry),
        .done          (done),
        .result        (result)
    );

endmodule

>>> tb/sps_selection_checker.sv
// checker for the supply profile selector: mirrors the slot table and checks each result word
`timescale 1ns / 100ps

module sps_selection_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  sps_pkg::sps_in_t               cmd,
    input  logic                           done,
    input  sps_pkg::sps_out_t              result,
    input  logic                           cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             outstanding,
    output int                             fail_count
);
    import sps_pkg::*;

    localparam int MARGIN_DV    = 5;
    localparam int NO_CTRL_DV   = 55;
    localparam int VOLT_CAP_DV  = 511;
    localparam int MAX_REPORTED = 10;

    // mirrored block state
    sps_entry_t        slots [SLOT_COUNT];
    logic [VOLT_W-1:0] last_required;
    logic [VOLT_W-1:0] board_min;
    logic [HEADROOM_W-1:0] headroom;

    sps_out_t pending_selections [$];
    int       reported;

    // profile voltages, ascending
    function automatic int profile_dv(input int idx);
        case (idx)
            0: return 50;
            1: return 90;
            2: return 120;
            3: return 150;
            4: return 180;
            default: return 200;
        endcase
    endfunction

    // largest need over the board minimum and every active slot
    function automatic int bus_requirement();
        int req;
        int need;
        req = int'(board_min);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slots[i].volts != '0) begin
                need = int'(slots[i].volts) + (slots[i].is_buck_boost ? 0 : int'(headroom));
                if (need > VOLT_CAP_DV) need = VOLT_CAP_DV;
                if (need > req) req = need;
            end
        end
        return req;
    endfunction

    // lowest offered profile that covers, else highest offered, else the 5 V one
    function automatic int pick_profile(input logic [PROFILE_COUNT-1:0] mask, input int req);
        for (int i = 0; i < PROFILE_COUNT; i++)
            if (mask[i] && (profile_dv(i) + MARGIN_DV >= req)) return i;
        for (int i = PROFILE_COUNT - 1; i >= 0; i--)
            if (mask[i]) return i;
        return 0;
    endfunction

    // expected result word of one command, updating the mirrored state
    function automatic sps_out_t select_outcome(input sps_in_t w);
        sps_out_t r;
        int       req;
        int       t;
        int       tv;
        int       diff;
        r.status         = ST_SATISFIED;
        r.target_profile = '0;
        r.required_volts = '0;
        r.success        = 1'b0;
        if (w.func == FUNC_VERIFY) begin
            r.required_volts = last_required;
            r.success = (int'(w.bus_volts) + MARGIN_DV >= int'(last_required));
            r.status  = r.success ? ST_SATISFIED : ST_INSUFFICIENT;
        end else if (int'(w.consumer_id) >= SLOT_COUNT) begin
            r.status = ST_INVALID_SLOT;
        end else begin
            slots[w.consumer_id].volts         = w.output_volts;
            slots[w.consumer_id].is_buck_boost = w.is_buck_boost;
            req = bus_requirement();
            last_required    = VOLT_W'(req);
            r.required_volts = VOLT_W'(req);
            if (!w.controller_present) begin
                r.success = (req <= NO_CTRL_DV);
                r.status  = r.success ? ST_SATISFIED : ST_UNAVAILABLE;
            end else if (!w.cable_attached) begin
                r.status = ST_NOT_ATTACHED;
            end else begin
                t    = pick_profile(w.offered_mask, req);
                tv   = profile_dv(t);
                diff = (int'(w.bus_volts) > tv) ? int'(w.bus_volts) - tv : tv - int'(w.bus_volts);
                r.target_profile = 3'(t);
                if (diff < MARGIN_DV) begin
                    r.status  = ST_SATISFIED;
                    r.success = 1'b1;
                end else begin
                    r.status  = ST_NEGOTIATE;
                    r.success = (tv + MARGIN_DV >= req);
                end
            end
        end
        return r;
    endfunction

    // watch config writes, accepted words and result words
    always @(posedge clk or negedge rst_n) begin : watch
        sps_out_t exp_word;
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) slots[i] = '0;
            last_required = '0;
            board_min     = BOARD_MINIMUM_RST;
            headroom      = BUCK_HEADROOM_RST;
            pending_selections.delete();
            reported      = 0;
            fail_count    = 0;
            outstanding  <= 0;
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_BOARD_MINIMUM: board_min = cfg_data[VOLT_W-1:0];
                    CFG_BUCK_HEADROOM: headroom  = cfg_data[HEADROOM_W-1:0];
                    default: ;
                endcase
            end
            // result word against the oldest expectation
            if (done) begin
                if (pending_selections.size() == 0) begin
                    fail_count++;
                    if (reported < MAX_REPORTED) begin
                        reported++;
                        $display("unexpected result word: status %0d profile %0d volts %0d ok %0d",
                                 result.status, result.target_profile,
                                 result.required_volts, result.success);
                    end
                end else begin
                    exp_word = pending_selections.pop_front();
                    if (result.status !== exp_word.status
                        || result.target_profile !== exp_word.target_profile
                        || result.required_volts !== exp_word.required_volts
                        || result.success !== exp_word.success) begin
                        fail_count++;
                        if (reported < MAX_REPORTED) begin
                            reported++;
                            $display("mismatch: expected status %0d profile %0d volts %0d ok %0d,",
                                     exp_word.status, exp_word.target_profile,
                                     exp_word.required_volts, exp_word.success);
                            $display("          got      status %0d profile %0d volts %0d ok %0d",
                                     result.status, result.target_profile,
                                     result.required_volts, result.success);
                        end
                    end
                end
            end
            // accepted command word
            if (start && !busy)
                pending_selections.push_back(select_outcome(cmd));
            outstanding <= pending_selections.size();
        end
    end

endmodule

>>> tb/tb_supply_profile_selector_top.sv
// testbench top for the supply profile selector: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_supply_profile_selector_top;
    import sps_pkg::*;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int PHASE_WORDS   = 300;
    localparam int PHASE_COUNT   = 6;
    localparam int SETTLE_CYCLES = 16;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    sps_in_t               cmd;
    logic                  done;
    sps_out_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    outstanding;
    int                    fail_count;
    int                    cycle_count = 0;

    // clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    supply_profile_selector_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    sps_selection_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic sps_in_t build_word(input logic func, input int id, input int volts,
                                           input logic bb, input logic present,
                                           input logic attached, input int mask,
                                           input int bus);
        sps_in_t w;
        w.func               = func;
        w.consumer_id        = 4'(id);
        w.output_volts       = VOLT_W'(volts);
        w.is_buck_boost      = bb;
        w.controller_present = present;
        w.cable_attached     = attached;
        w.offered_mask       = PROFILE_COUNT'(mask);
        w.bus_volts          = BUS_W'(bus);
        return w;
    endfunction

    // mostly valid ensure words with the controller and cable up, some noise
    function automatic sps_in_t random_word();
        sps_in_t w;
        int      k;
        w.func = ($urandom_range(0, 99) < 12) ? FUNC_VERIFY : FUNC_ENSURE;
        w.consumer_id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                    : 4'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0, 1:    w.output_volts = '0;
            2, 3:    w.output_volts = VOLT_W'($urandom_range(0, 60));
            4, 5, 6: w.output_volts = VOLT_W'($urandom_range(30, 200));
            default: w.output_volts = VOLT_W'($urandom_range(0, 511));
        endcase
        w.is_buck_boost      = 1'($urandom_range(0, 1));
        w.controller_present = ($urandom_range(0, 9) != 0);
        w.cable_attached     = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0, 1:    w.offered_mask = '1;
            2:       w.offered_mask = PROFILE_COUNT'(1 << $urandom_range(0, 5));
            default: w.offered_mask = PROFILE_COUNT'($urandom_range(0, 63));
        endcase
        // bus voltage often close to a profile so both sides of the margin occur
        if ($urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, PROFILE_COUNT - 1);
            w.bus_volts = BUS_W'(int'(PROFILE_VOLTS[k]) + $urandom_range(0, 12) - 6);
        end else begin
            w.bus_volts = BUS_W'($urandom_range(0, 255));
        end
        return w;
    endfunction

    // hold the word on cmd until the block takes it
    task automatic send_word(input sps_in_t w);
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
    endtask

    // let every expected result word arrive
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // write both registers, block idle
    task automatic set_config(input int bm, input int hr);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BOARD_MINIMUM;
        cfg_data <= CFG_DATA_W'(bm);
        @(posedge clk);
        cfg_idx  <= CFG_BUCK_HEADROOM;
        cfg_data <= CFG_DATA_W'(hr);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int  bm;
        int  hr;
        bit  idling;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset settings
        send_word(build_word(FUNC_VERIFY, 0, 0, 0, 1, 1, 63, 0));
        send_word(build_word(FUNC_ENSURE, 0, 0, 0, 0, 1, 63, 0));
        send_word(build_word(FUNC_ENSURE, 3, 120, 0, 1, 1, 63, 150));
        send_word(build_word(FUNC_ENSURE, 3, 120, 0, 1, 1, 63, 154));
        send_word(build_word(FUNC_ENSURE, 3, 120, 0, 1, 1, 63, 155));
        send_word(build_word(FUNC_VERIFY, 0, 0, 0, 0, 0, 0, 130));
        send_word(build_word(FUNC_VERIFY, 15, 511, 1, 1, 1, 63, 129));
        send_word(build_word(FUNC_ENSURE, 8, 200, 0, 1, 1, 63, 50));
        send_word(build_word(FUNC_ENSURE, 15, 511, 1, 1, 1, 63, 255));
        // saturated requirement falls back to the highest offered profile
        send_word(build_word(FUNC_ENSURE, 7, 511, 1, 1, 1, 63, 255));
        send_word(build_word(FUNC_ENSURE, 7, 500, 0, 1, 1, 7, 0));
        send_word(build_word(FUNC_ENSURE, 7, 0, 0, 1, 0, 63, 150));
        // nothing offered, then single high profile
        send_word(build_word(FUNC_ENSURE, 3, 0, 0, 1, 1, 0, 50));
        send_word(build_word(FUNC_ENSURE, 1, 200, 1, 1, 1, 32, 0));
        send_word(build_word(FUNC_ENSURE, 1, 0, 0, 1, 1, 63, 90));

        // directed words around the no-controller limit
        set_config(40, 0);
        send_word(build_word(FUNC_ENSURE, 0, 50, 0, 0, 1, 63, 0));
        send_word(build_word(FUNC_ENSURE, 0, 55, 1, 0, 0, 0, 0));
        send_word(build_word(FUNC_ENSURE, 0, 56, 0, 0, 1, 63, 0));
        send_word(build_word(FUNC_VERIFY, 0, 0, 0, 1, 1, 63, 51));
        send_word(build_word(FUNC_VERIFY, 0, 0, 0, 1, 1, 63, 50));
        send_word(build_word(FUNC_VERIFY, 0, 0, 0, 1, 1, 63, 255));
        send_word(build_word(FUNC_ENSURE, 0, 0, 0, 1, 1, 63, 0));

        // random phases over several register settings
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin bm = 0;   hr = 0;   end
                1: begin bm = 511; hr = 100; end
                2: begin bm = $urandom_range(0, 160); hr = $urandom_range(0, 100); end
                3: begin bm = 0;   hr = 100; end
                4: begin bm = 511; hr = 0;   end
                default: begin bm = $urandom_range(0, 120); hr = $urandom_range(0, 40); end
            endcase
            set_config(bm, hr);
            idling = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 50 == 0) idling = ($urandom_range(0, 3) != 0);
                send_word(random_word());
                // no idling in the last phase
                if (p < PHASE_COUNT - 1 && idling && $urandom_range(0, 2) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_decide.sv
rtl/sps_slot_mem.sv
rtl/sps_ctrl.sv
rtl/supply_profile_selector_top.sv
tb/sps_selection_checker.sv
tb/tb_supply_profile_selector_top.sv
